>>> rtl/yaz0_pkg.sv
package yaz0_pkg;

    localparam int unsigned WIN_BITS = 12;
    localparam int unsigned WIN_DEPTH = 4096;
    localparam int unsigned MAX_CHUNK = 8;

    localparam logic [1:0] REG_OUT_LENGTH = 2'd0;

    localparam logic [1:0] PH_TOKEN  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic [8:0] LONG_BIAS  = 9'h12;
    localparam logic [4:0] SHORT_BIAS = 5'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                we;
        logic [WIN_BITS-1:0] waddr;
        logic [7:0]          wdata;
        logic [WIN_BITS-1:0] raddr;
    } t_hist_req;

endpackage

>>> rtl/yaz0_hist_ram.sv
module yaz0_hist_ram (
    input  logic                  i_clk,
    input  yaz0_pkg::t_hist_req   i_req,
    output logic [7:0]            o_rdata
);
    import yaz0_pkg::*;

    logic [7:0] r_mem [WIN_DEPTH];

    // write one byte, read one byte, both registered
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

>>> rtl/yaz0_lz_decompressor.sv
// Yaz0 LZ decompressor.
// Input channel (i_in_valid/o_in_ready) takes one compressed byte per request,
// header already stripped; i_first marks the first byte of a new stream and
// clears the decoder state. Output channel (o_out_valid/i_out_ready) gives
// results of up to eight bytes each, with byte_count, run_last, stream_done
// and bad_ref. out_length is written over the APB port at address 0.
// Header and token bytes are taken in the idle state; a literal goes to the
// emit state and from there into the output register. A back-reference copies
// through the 4096-byte history RAM one byte at a time, in a read state and
// then a write-back state, and each result of up to eight bytes passes
// through the emit state to the output register. Input is held off while a
// copy runs.
// The output register decouples the sides: the next request is accepted
// while the last result waits; a stalled receiver holds a copy only when a
// further result is ready.
// Reset clears the decoder state, out_length and the output valid; the
// history RAM is not cleared, as reads never reach unwritten entries.
module yaz0_lz_decompressor #(
    parameter int unsigned BYTES_PER_RESULT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_first,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_0,
    output logic [7:0]  o_data_1,
    output logic [7:0]  o_data_2,
    output logic [7:0]  o_data_3,
    output logic [7:0]  o_data_4,
    output logic [7:0]  o_data_5,
    output logic [7:0]  o_data_6,
    output logic [7:0]  o_data_7,
    output logic [3:0]  o_byte_count,
    output logic        o_run_last,
    output logic        o_stream_done,
    output logic        o_bad_ref,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import yaz0_pkg::*;

    localparam int unsigned CHUNK = (BYTES_PER_RESULT > MAX_CHUNK) ? MAX_CHUNK
                                                                  : BYTES_PER_RESULT;
    localparam logic [3:0] CHUNK_W = 4'(CHUNK);

    t_state r_state, n_state;

    logic [31:0]         r_out_length;
    logic [WIN_BITS-1:0] r_wp, n_wp;
    logic [31:0]         r_count, n_count;
    logic [7:0]          r_bits, n_bits;
    logic [3:0]          r_left, n_left;
    logic [1:0]          r_phase, n_phase;
    logic [7:0]          r_rf, n_rf;
    logic [7:0]          r_rs, n_rs;
    logic [WIN_BITS-1:0] r_src, n_src;
    logic [8:0]          r_len, n_len;
    logic [3:0]          r_cnt, n_cnt;
    logic                r_last, n_last;
    logic                r_bad, n_bad;
    logic [7:0]          r_buf [MAX_CHUNK];

    logic                r_ovalid;
    logic [7:0]          r_odata [MAX_CHUNK];
    logic [3:0]          r_ocount;
    logic                r_olast, r_odone, r_obad;

    t_hist_req           hist_req;
    logic [7:0]          hist_rdata;

    logic                in_acc, lit_acc, copy_go, emit_go, wr_end;
    logic [12:0]         need;
    logic [31:0]         e_count;
    logic [7:0]          e_rf;
    logic [WIN_BITS-1:0] e_wp;

    yaz0_hist_ram u_hist (
        .i_clk   (i_clk),
        .i_req   (hist_req),
        .o_rdata (hist_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[3:2] == REG_OUT_LENGTH) ? r_out_length : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_length <= 32'd0;
        end else if (psel && penable && pwrite && paddr[3:2] == REG_OUT_LENGTH) begin
            r_out_length <= pwdata;
        end
    end

    // handshake and memory control
    assign in_acc  = i_in_valid && o_in_ready;
    assign emit_go = (r_state == ST_EMIT) && (!r_ovalid || i_out_ready);

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        hist_req.we    = lit_acc || (r_state == ST_WR);
        hist_req.waddr = (r_state == ST_WR) ? r_wp : e_wp;
        hist_req.wdata = (r_state == ST_WR) ? hist_rdata : i_in_byte;
        hist_req.raddr = r_src;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (lit_acc || (copy_go && n_bad)) begin
                    n_state = ST_EMIT;
                end else if (copy_go) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: n_state = ST_WR;
            ST_WR: begin
                if (wr_end || (r_cnt + 4'd1 == CHUNK_W)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    n_state = r_last ? ST_IDLE : ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // token decode and copy bookkeeping
    always_comb begin
        logic [1:0] e_phase;
        logic [3:0] e_left;
        logic [7:0] e_bits, e_rs;
        e_left  = i_first ? 4'd0 : r_left;
        e_bits  = i_first ? 8'd0 : r_bits;
        e_phase = i_first ? PH_TOKEN : r_phase;
        e_rf    = i_first ? 8'd0 : r_rf;
        e_rs    = i_first ? 8'd0 : r_rs;
        e_count = i_first ? 32'd0 : r_count;
        e_wp    = i_first ? '0 : r_wp;

        n_wp = r_wp;  n_count = r_count; n_bits = r_bits; n_left = r_left;
        n_phase = r_phase; n_rf = r_rf; n_rs = r_rs; n_src = r_src;
        n_len = r_len; n_cnt = r_cnt; n_last = r_last; n_bad = 1'b0;
        lit_acc = 1'b0;
        copy_go = 1'b0;
        need    = 13'd0;
        wr_end  = 1'b0;

        if (r_state == ST_IDLE && in_acc) begin
            n_wp = e_wp; n_count = e_count; n_bits = e_bits; n_left = e_left;
            n_phase = e_phase; n_rf = e_rf; n_rs = e_rs;
            if (e_count < r_out_length) begin
                priority if (e_phase == PH_SECOND) begin
                    n_rs = i_in_byte;
                    if (e_rf[7:4] != 4'd0) begin
                        copy_go = 1'b1;
                        n_len   = {5'd0, e_rf[7:4]} + {4'd0, SHORT_BIAS};
                    end else begin
                        n_phase = PH_THIRD;
                    end
                end else if (e_phase == PH_THIRD) begin
                    copy_go = 1'b1;
                    n_len   = {1'b0, i_in_byte} + LONG_BIAS;
                end else if (e_left == 4'd0) begin
                    n_bits = i_in_byte;
                    n_left = 4'd8;
                end else if (e_bits[7]) begin
                    lit_acc = 1'b1;
                    n_wp    = e_wp + 1'b1;
                    n_count = e_count + 32'd1;
                    n_bits  = {e_bits[6:0], 1'b0};
                    n_left  = e_left - 4'd1;
                    n_cnt   = 4'd1;
                    n_last  = 1'b1;
                end else begin
                    n_rf    = i_in_byte;
                    n_phase = PH_SECOND;
                end
                if (copy_go) begin
                    need    = {1'b0, e_rf[3:0], n_rs} + 13'd1;
                    n_bits  = {e_bits[6:0], 1'b0};
                    n_left  = (e_left != 4'd0) ? e_left - 4'd1 : 4'd0;
                    n_phase = PH_TOKEN;
                    n_cnt   = 4'd0;
                    n_src   = e_wp - need[WIN_BITS-1:0];
                    n_bad   = {19'd0, need} > e_count;
                    n_last  = n_bad;
                end
            end
        end else if (r_state == ST_WR) begin
            n_wp    = r_wp + 1'b1;
            n_src   = r_src + 1'b1;
            n_count = r_count + 32'd1;
            n_len   = r_len - 9'd1;
            n_cnt   = r_cnt + 4'd1;
            wr_end  = (r_len == 9'd1) || (r_count + 32'd1 >= r_out_length);
            n_last  = wr_end;
        end else if (emit_go) begin
            n_cnt = 4'd0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_count <= 32'd0;
            r_bits  <= 8'd0;
            r_left  <= 4'd0;
            r_phase <= PH_TOKEN;
            r_rf    <= 8'd0;
            r_rs    <= 8'd0;
            r_cnt   <= 4'd0;
            r_last  <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_count <= n_count;
            r_bits  <= n_bits;
            r_left  <= n_left;
            r_phase <= n_phase;
            r_rf    <= n_rf;
            r_rs    <= n_rs;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            if (r_state == ST_IDLE && in_acc) begin
                r_bad <= n_bad;
            end
        end
    end

    // copy pointers and chunk buffer
    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_len <= n_len;
        if (lit_acc) begin
            r_buf[0] <= i_in_byte;
        end else if (r_state == ST_WR) begin
            r_buf[r_cnt[2:0]] <= hist_rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_go) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            for (int j = 0; j < MAX_CHUNK; j++) begin
                r_odata[j] <= (4'(j) < r_cnt) ? r_buf[j] : 8'd0;
            end
            r_ocount <= r_cnt;
            r_olast  <= r_last;
            r_obad   <= r_bad;
            r_odone  <= !r_bad && (r_count >= r_out_length);
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_data_0      = r_odata[0];
    assign o_data_1      = r_odata[1];
    assign o_data_2      = r_odata[2];
    assign o_data_3      = r_odata[3];
    assign o_data_4      = r_odata[4];
    assign o_data_5      = r_odata[5];
    assign o_data_6      = r_odata[6];
    assign o_data_7      = r_odata[7];
    assign o_byte_count  = r_ocount;
    assign o_run_last    = r_olast;
    assign o_stream_done = r_odone;
    assign o_bad_ref     = r_obad;

endmodule

>>> rtl/yaz0_checker.sv
module yaz0_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_byte_count,
    input logic       o_run_last,
    input logic       o_stream_done,
    input logic       o_bad_ref,
    input logic       pready
);

    // a stalled result keeps its size
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_byte_count))
        else $error("stalled result changed");

    // a bad reference carries no bytes and closes its run
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_ref |-> o_byte_count == 4'd0 && o_run_last && !o_stream_done)
        else $error("bad reference result malformed");

    // a normal result holds one to eight bytes
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bad_ref |-> o_byte_count != 4'd0 && o_byte_count <= 4'd8)
        else $error("byte count out of range");

    // the end of the stream always ends a run
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_done |-> o_run_last)
        else $error("stream done inside a run");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind yaz0_lz_decompressor yaz0_checker u_yaz0_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_byte_count  (o_byte_count),
    .o_run_last    (o_run_last),
    .o_stream_done (o_stream_done),
    .o_bad_ref     (o_bad_ref),
    .pready        (pready)
);

>>> bench/yaz0_lz_decompressor_test.sv
module yaz0_lz_decompressor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import yaz0_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 80;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [7:0] d [8];
        logic [3:0] cnt;
        logic       last;
        logic       done;
        logic       bad;
    } t_chunk;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_first;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_data_0, o_data_1, o_data_2, o_data_3;
    logic [7:0]  o_data_4, o_data_5, o_data_6, o_data_7;
    logic [3:0]  o_byte_count;
    logic        o_run_last;
    logic        o_stream_done;
    logic        o_bad_ref;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    yaz0_lz_decompressor u_top (.*);

    // decoder mirror
    logic [7:0]  win [WIN_DEPTH];
    logic [11:0] wpos;
    logic [31:0] produced;
    logic [7:0]  flags;
    logic [3:0]  flags_left;
    logic [1:0]  phase;
    logic [7:0]  tok_first;
    logic [7:0]  tok_second;
    logic [31:0] stop_len;
    logic [7:0]  run_buf [288];

    t_chunk      chunk_q [$];
    int          errors;
    int          idle_cycles;
    int          burst_left;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_mirror();
        wpos = '0;
        produced = '0;
        flags = '0;
        flags_left = '0;
        phase = PH_TOKEN;
        tok_first = '0;
        tok_second = '0;
    endfunction

    function automatic void take_flag();
        flags = flags << 1;
        if (flags_left != 0) flags_left = flags_left - 1'b1;
        phase = PH_TOKEN;
    endfunction

    // split a run of produced bytes into chunks of up to eight
    function automatic void queue_run(input int n, input logic [31:0] start);
        int     pos;
        int     k;
        t_chunk c;
        pos = 0;
        while (pos < n) begin
            k = (n - pos > MAX_CHUNK) ? MAX_CHUNK : n - pos;
            for (int j = 0; j < 8; j++) c.d[j] = (j < k) ? run_buf[pos + j] : 8'h00;
            c.cnt  = 4'(k);
            c.last = (pos + k >= n);
            c.done = ({32'h0, start} + 64'(pos + k) >= {32'h0, stop_len});
            c.bad  = 1'b0;
            chunk_q.push_back(c);
            pos += k;
        end
    endfunction

    function automatic void copy_run(input int len);
        int          n;
        logic [31:0] start;
        logic [12:0] ref_dist;
        logic [11:0] src;
        t_chunk      c;
        n = 0;
        start = produced;
        ref_dist = {1'b0, tok_first[3:0], tok_second} + 13'd1;
        take_flag();
        if ({19'h0, ref_dist} > produced) begin
            for (int j = 0; j < 8; j++) c.d[j] = 8'h00;
            c.cnt = '0;
            c.last = 1'b1;
            c.done = 1'b0;
            c.bad = 1'b1;
            chunk_q.push_back(c);
            return;
        end
        src = wpos - ref_dist[11:0];
        for (int i = 0; i < len && produced < stop_len; i++) begin
            run_buf[n] = win[src];
            win[wpos] = win[src];
            src++;
            wpos++;
            produced++;
            n++;
        end
        queue_run(n, start);
    endfunction

    function automatic void predict(input logic [7:0] b, input logic f);
        if (f) clear_mirror();
        if (produced >= stop_len) return;
        if (phase == PH_SECOND) begin
            tok_second = b;
            if (tok_first[7:4] != 0) begin
                copy_run(int'(tok_first[7:4]) + int'(SHORT_BIAS));
                return;
            end
            phase = PH_THIRD;
            return;
        end
        if (phase == PH_THIRD) begin
            copy_run(int'(b) + int'(LONG_BIAS));
            return;
        end
        if (flags_left == 0) begin
            flags = b;
            flags_left = 4'd8;
            return;
        end
        if (flags[7]) begin
            run_buf[0] = b;
            win[wpos] = b;
            wpos++;
            produced++;
            take_flag();
            queue_run(1, produced - 1);
            return;
        end
        tok_first = b;
        phase = PH_SECOND;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // offer one request, hold it until taken, then maybe open a gap
    task automatic send_byte(input logic [7:0] b, input logic f);
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_first    <= f;
        do @(posedge i_clk); while (!o_in_ready);
        predict(b, f);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
        end
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chunk_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [31:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_OUT_LENGTH, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        stop_len = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata != v) report("out_length readback", prdata, v);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one stream with random content, now and then a stray byte or an out-of-reach
    // distance; a long-only run carries on the stream already open
    task automatic run_stream(input int groups, input bit long_only);
        logic [7:0]  hdr;
        logic [11:0] dcode;
        int          avail;
        for (int g = 0; g < groups; g++) begin
            if (!long_only && g != 0 && $urandom_range(0, 9) == 0)
                send_byte(8'($urandom), 1'($urandom));
            hdr = long_only ? 8'h00 : 8'($urandom);
            send_byte(hdr, g == 0 && !long_only);
            for (int k = 7; k >= 0; k--) begin
                if (hdr[k]) begin
                    send_byte(8'($urandom), 1'b0);
                end else begin
                    avail = (produced > 4096) ? 4096 : int'(produced);
                    if (avail == 0 || $urandom_range(0, 15) == 0)
                        dcode = 12'($urandom);
                    else
                        dcode = 12'($urandom_range(1, avail) - 1);
                    if (long_only || $urandom_range(0, 3) == 0) begin
                        send_byte({4'h0, dcode[11:8]}, 1'b0);
                        send_byte(dcode[7:0], 1'b0);
                        send_byte(long_only ? 8'hFF :
                                  ($urandom_range(0, 7) == 0 ? 8'($urandom) :
                                   8'($urandom_range(0, 15))), 1'b0);
                    end else begin
                        send_byte({4'($urandom_range(1, 15)), dcode[11:8]}, 1'b0);
                        send_byte(dcode[7:0], 1'b0);
                    end
                end
            end
        end
    endtask

    task automatic test_directed();
        // out_length still at its reset value: nothing comes out
        send_byte(8'hFF, 1'b1);
        send_byte(8'h41, 1'b0);
        write_length(32'hFFFF_FFFF);
        send_byte(8'hA0, 1'b1);   // literal, ref, literal, ref ...
        send_byte(8'h00, 1'b0);
        send_byte(8'hF0, 1'b0);   // short ref, longest nibble, distance 1
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);   // long ref, maximal extra byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);   // reach before the first byte
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);   // nibble one, distance 2
        send_byte(8'h01, 1'b0);
        write_length(32'd5);
        send_byte(8'hC0, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);   // copy cut at the stop length
        send_byte(8'h01, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h77, 1'b0);   // ignored once done
        write_length(32'd0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h12, 1'b0);
    endtask

    task automatic test_random();
        int items_sent;
        logic [31:0] len;
        for (int s = 0; s < 3; s++) begin
            case ($urandom_range(0, 3))
                0: len = 32'($urandom_range(1, 20));
                1: len = 32'($urandom_range(20, 400));
                2: len = 32'hFFFF_FFFF;
                default: len = $urandom;
            endcase
            write_length(len);
            run_stream($urandom_range(1, 2), 1'b0);
        end
        // unstructured noise
        for (int i = 0; i < 20; i++)
            send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
    endtask

    task automatic test_window_wrap();
        write_length(32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b1);
        for (int i = 0; i < 8; i++) send_byte(8'($urandom), 1'b0);
        run_stream(3, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0F, 1'b0);   // farthest distance
        send_byte(8'hFF, 1'b0);
        send_byte(8'h20, 1'b0);
    endtask

    task automatic test_backpressure();
        write_length(32'hFFFF_FFFF);
        hold_req = 1'b1;
        burst_left = 1000;
        send_byte(8'hFF, 1'b1);
        for (int i = 0; i < 16; i++) send_byte(8'($urandom), 1'b0);
        send_byte(8'h00, 1'b0);
        for (int i = 0; i < 8; i++) begin
            send_byte(8'hF0, 1'b0);
            send_byte(8'h03, 1'b0);
        end
        burst_left = 0;
        drain();
        run_stream(1, 1'b0);
    endtask

    // long receiver hold-off
    initial begin
        hold_req = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end
        end
    end

    // receiver: check each result and stall on its own pattern
    initial begin : receiver
        int     mode;
        int     mode_left;
        t_chunk c;
        logic [7:0] got [8];
        mode = 0;
        mode_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got = '{o_data_0, o_data_1, o_data_2, o_data_3,
                        o_data_4, o_data_5, o_data_6, o_data_7};
                if (chunk_q.size() == 0) begin
                    $display("mismatch: result with nothing expected");
                    errors++;
                end else begin
                    c = chunk_q.pop_front();
                    for (int j = 0; j < 8; j++)
                        if (got[j] !== c.d[j]) report($sformatf("data_%0d", j), got[j], c.d[j]);
                    if (o_byte_count !== c.cnt) report("byte_count", o_byte_count, c.cnt);
                    if (o_run_last !== c.last) report("run_last", o_run_last, c.last);
                    if (o_stream_done !== c.done) report("stream_done", o_stream_done, c.done);
                    if (o_bad_ref !== c.bad) report("bad_ref", o_bad_ref, c.bad);
                end
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            if (hold_req) i_out_ready <= 1'b0;
            else case (mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on cycles with no accepted request or result
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("yaz0_lz_decompressor regression: fail");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        burst_left = 0;
        stop_len = '0;
        clear_mirror();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_byte  <= '0;
        i_first    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_window_wrap();
        test_backpressure();
        drain();
        if (errors == 0) begin
            $display("yaz0_lz_decompressor regression: pass");
        end else begin
            $display("yaz0_lz_decompressor regression: fail");
        end
        $finish;
    end

endmodule
